// File: hw/rtl/chip8_register_alu_execute_core_defines.svh
// Assertion macros shared by the checker of the execute core.
// Depends on nothing; include by bare file name.
`ifndef CHIP8_REGISTER_ALU_EXECUTE_CORE_DEFINES_SVH
`define CHIP8_REGISTER_ALU_EXECUTE_CORE_DEFINES_SVH

// Same-cycle implication on clk_i, disabled while rst_ni is low.
`define C8ALU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk_i, disabled while rst_ni is low.
`define C8ALU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/c8alu_pkg.sv
// Package of the CHIP-8 style execute core: operation codes, item structs,
// the request and response structs of the ALU, and default parameters.
package c8alu_pkg;

  localparam int unsigned PROGRAM_BASE_DEF = 512;
  localparam int unsigned STACK_DEPTH_DEF  = 16;
  localparam int unsigned VREG_COUNT       = 16;
  localparam logic [3:0]  VREG_FLAG        = 4'hF;
  localparam logic [3:0]  VREG_ZERO        = 4'h0;
  localparam logic [15:0] PC_STEP          = 16'd2;
  localparam logic [15:0] FONT_STRIDE      = 16'd5;

  typedef enum logic [4:0] {
    FUNC_RET     = 5'd0,
    FUNC_JMP     = 5'd1,
    FUNC_CALL    = 5'd2,
    FUNC_SEQ_IMM = 5'd3,
    FUNC_SNE_IMM = 5'd4,
    FUNC_SEQ_REG = 5'd5,
    FUNC_LD_IMM  = 5'd6,
    FUNC_ADD_IMM = 5'd7,
    FUNC_MOV     = 5'd8,
    FUNC_OR      = 5'd9,
    FUNC_AND     = 5'd10,
    FUNC_XOR     = 5'd11,
    FUNC_ADD     = 5'd12,
    FUNC_SUB     = 5'd13,
    FUNC_SHR     = 5'd14,
    FUNC_SUBN    = 5'd15,
    FUNC_SHL     = 5'd16,
    FUNC_SNE_REG = 5'd17,
    FUNC_LD_I    = 5'd18,
    FUNC_JMP_V0  = 5'd19,
    FUNC_RND     = 5'd20,
    FUNC_RD_DT   = 5'd21,
    FUNC_LD_DT   = 5'd22,
    FUNC_ADD_I   = 5'd23,
    FUNC_FONT    = 5'd24
  } func_e;

  typedef struct packed {
    logic [4:0]  func;
    logic [3:0]  reg_x;
    logic [3:0]  reg_y;
    logic [7:0]  imm_byte;
    logic [11:0] target_addr;
    logic [7:0]  random_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] new_pc;
    logic [15:0] new_index;
    logic [7:0]  vx_value;
    logic [7:0]  flag_value;
    logic [7:0]  delay_value;
  } out_item_t;

  // Operands and architectural state handed to the ALU.
  typedef struct packed {
    in_item_t    item;
    logic [7:0]  vx;
    logic [7:0]  vy;
    logic [7:0]  vf;
    logic [15:0] pc;
    logic [15:0] index;
    logic [7:0]  delay;
    logic [15:0] stack_top;
  } alu_req_t;

  // Next state and write-back controls from the ALU.
  typedef struct packed {
    logic [15:0] pc;
    logic [15:0] index;
    logic [7:0]  delay;
    logic [7:0]  vf;
    logic [7:0]  vx;
    logic        vreg_we;
    logic        push;
    logic        pop;
  } alu_rsp_t;

endpackage

// File: hw/rtl/chip8_register_alu_execute_core.sv
// Top level of the CHIP-8 style execute core: two-stage read-modify-write
// around the V register RAM and the return stack RAM. Depends on c8alu_pkg,
// c8alu_ram and c8alu_alu.
//
// The core executes one decoded instruction per transfer and returns one
// result per instruction: PC, I, Vx, VF and the delay register as they stand
// after it. An accepted instruction passes the execute stage, then the
// result register, and while the input is not stalled a new instruction
// can be accepted at every edge, so the sustained rate is one instruction
// per cycle. The rate is set by the single read-modify-write pass through
// the V register RAM and the stack RAM: operands are read at acceptance,
// the ALU result is written back as the stage advances, and a write in the
// same cycle as the next read is forwarded; back-to-back dependent instructions
// need no bubbles. VF, PC, I, the stack pointer and the delay register live
// in flip-flops. Both RAMs read as zero after reset through per-entry valid
// bits, so no clearing pass is needed. The input is stalled only when the
// result register is full and the output side stalls while an instruction
// is waiting in the execute stage.
module chip8_register_alu_execute_core #(
  parameter int unsigned PROGRAM_BASE = c8alu_pkg::PROGRAM_BASE_DEF,
  parameter int unsigned STACK_DEPTH  = c8alu_pkg::STACK_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  c8alu_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output c8alu_pkg::out_item_t out_data_o
);

  localparam int unsigned SP_W    = $clog2(STACK_DEPTH);
  localparam int unsigned VR_N    = c8alu_pkg::VREG_COUNT;
  localparam logic [SP_W-1:0] SP_LAST = SP_W'(STACK_DEPTH - 1);

  // Execute stage
  logic                s1_valid_q, s1_valid_d;
  c8alu_pkg::in_item_t s1_item_q;
  logic [3:0]          s1_yaddr_q;
  logic                in_xfer, s1_adv;

  // Result register
  logic                 out_valid_q, out_valid_d;
  c8alu_pkg::out_item_t out_item_q;

  // Architectural flip-flop state
  logic [15:0]     pc_q, pc_d, idx_q, idx_d;
  logic [7:0]      dt_q, dt_d, vf_q, vf_d;
  logic [SP_W-1:0] sp_q, sp_d, sp_push, sp_pop;

  // Valid bits and forwarding of the last write of each RAM
  logic [VR_N-1:0]        vvalid_q;
  logic [STACK_DEPTH-1:0] svalid_q;
  logic                   vfwd_en_q, sfwd_en_q;
  logic [3:0]             vfwd_addr_q;
  logic [7:0]             vfwd_data_q;
  logic [SP_W-1:0]        sfwd_addr_q;
  logic [15:0]            sfwd_data_q;

  // RAM ports
  logic [3:0]      vr_raddr [2];
  logic [7:0]      vr_rdata [2];
  logic            vr_we;
  logic [SP_W-1:0] st_raddr [1];
  logic [15:0]     st_rdata [1];
  logic            st_we;
  logic [SP_W-1:0] st_waddr;
  logic [15:0]     st_wdata;

  c8alu_pkg::alu_req_t alu_req;
  c8alu_pkg::alu_rsp_t alu_rsp;

  // Handshake: hold the execute stage only while the result waits stalled.
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Read Vx and Vy at acceptance; jump+V0 reads V0 on the second port.
  assign vr_raddr[0] = in_data_i.reg_x;
  assign vr_raddr[1] = (in_data_i.func == c8alu_pkg::FUNC_JMP_V0) ?
                       c8alu_pkg::VREG_ZERO : in_data_i.reg_y;
  // Read the slot the pointer will point at once the current op retires.
  assign st_raddr[0] = sp_d;

  c8alu_ram #(
    .WIDTH    (8),
    .DEPTH    (VR_N),
    .RD_PORTS (2)
  ) u_vregs (
    .clk_i   (clk_i),
    .we_i    (vr_we),
    .waddr_i (s1_item_q.reg_x),
    .wdata_i (alu_rsp.vx),
    .re_i    (in_xfer),
    .raddr_i (vr_raddr),
    .rdata_o (vr_rdata)
  );

  c8alu_ram #(
    .WIDTH    (16),
    .DEPTH    (STACK_DEPTH),
    .RD_PORTS (1)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (in_xfer),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // Resolve a V register operand: VF from its flip-flop, the last write by
  // forwarding, an unwritten entry as zero, else the RAM data.
  function automatic logic [7:0] pick_vreg(
    input logic [3:0]      addr,
    input logic [7:0]      ram_data,
    input logic [7:0]      vf,
    input logic            fwd_en,
    input logic [3:0]      fwd_addr,
    input logic [7:0]      fwd_data,
    input logic [VR_N-1:0] valid
  );
    logic [7:0] val;
    if (addr == c8alu_pkg::VREG_FLAG) begin
      val = vf;
    end else if (fwd_en && (fwd_addr == addr)) begin
      val = fwd_data;
    end else if (valid[addr]) begin
      val = ram_data;
    end else begin
      val = 8'd0;
    end
    return val;
  endfunction

  always_comb begin
    alu_req.item  = s1_item_q;
    alu_req.vx    = pick_vreg(s1_item_q.reg_x, vr_rdata[0], vf_q, vfwd_en_q,
                              vfwd_addr_q, vfwd_data_q, vvalid_q);
    alu_req.vy    = pick_vreg(s1_yaddr_q, vr_rdata[1], vf_q, vfwd_en_q,
                              vfwd_addr_q, vfwd_data_q, vvalid_q);
    alu_req.vf    = vf_q;
    alu_req.pc    = pc_q;
    alu_req.index = idx_q;
    alu_req.delay = dt_q;
    if (sfwd_en_q && (sfwd_addr_q == sp_q)) begin
      alu_req.stack_top = sfwd_data_q;
    end else if (svalid_q[sp_q]) begin
      alu_req.stack_top = st_rdata[0];
    end else begin
      alu_req.stack_top = 16'd0;
    end
  end

  c8alu_alu #(
    .PROGRAM_BASE (PROGRAM_BASE)
  ) u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // Write-back and next state, all taken when the execute stage advances.
  always_comb begin
    sp_push  = (sp_q == SP_LAST) ? '0 : sp_q + SP_W'(1);
    sp_pop   = (sp_q == '0) ? SP_LAST : sp_q - SP_W'(1);
    vr_we    = s1_adv && alu_rsp.vreg_we;
    st_we    = s1_adv && (alu_rsp.push || alu_rsp.pop);
    // Push stores the current PC at the new slot; pop clears the old slot.
    st_waddr = alu_rsp.push ? sp_push : sp_q;
    st_wdata = alu_rsp.push ? pc_q : 16'd0;

    sp_d  = sp_q;
    pc_d  = pc_q;
    idx_d = idx_q;
    dt_d  = dt_q;
    vf_d  = vf_q;
    if (s1_adv) begin
      pc_d  = alu_rsp.pc;
      idx_d = alu_rsp.index;
      dt_d  = alu_rsp.delay;
      vf_d  = alu_rsp.vf;
      if (alu_rsp.push) begin
        sp_d = sp_push;
      end else if (alu_rsp.pop) begin
        sp_d = sp_pop;
      end
    end

    s1_valid_d = in_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);

    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= 16'(PROGRAM_BASE);
      idx_q       <= 16'd0;
      dt_q        <= 8'd0;
      vf_q        <= 8'd0;
      sp_q        <= '0;
      vvalid_q    <= '0;
      svalid_q    <= '0;
      vfwd_en_q   <= 1'b0;
      sfwd_en_q   <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      pc_q        <= pc_d;
      idx_q       <= idx_d;
      dt_q        <= dt_d;
      vf_q        <= vf_d;
      sp_q        <= sp_d;
      if (vr_we) begin
        vvalid_q[s1_item_q.reg_x] <= 1'b1;
        vfwd_en_q                 <= 1'b1;
      end
      if (st_we) begin
        svalid_q[st_waddr] <= 1'b1;
        sfwd_en_q          <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q  <= in_data_i;
      s1_yaddr_q <= vr_raddr[1];
    end
    if (vr_we) begin
      vfwd_addr_q <= s1_item_q.reg_x;
      vfwd_data_q <= alu_rsp.vx;
    end
    if (st_we) begin
      sfwd_addr_q <= st_waddr;
      sfwd_data_q <= st_wdata;
    end
    if (s1_adv) begin
      out_item_q.new_pc      <= alu_rsp.pc;
      out_item_q.new_index   <= alu_rsp.index;
      out_item_q.vx_value    <= alu_rsp.vx;
      out_item_q.flag_value  <= alu_rsp.vf;
      out_item_q.delay_value <= alu_rsp.delay;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

endmodule

// File: hw/rtl/c8alu_ram.sv
// Generic synchronous RAM: one write port, RD_PORTS registered read ports.
// Depends on nothing.
module c8alu_ram #(
  parameter int unsigned WIDTH    = 8,
  parameter int unsigned DEPTH    = 16,
  parameter int unsigned RD_PORTS = 1,
  localparam int unsigned AW      = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i [RD_PORTS],
  output logic [WIDTH-1:0] rdata_o [RD_PORTS]
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  for (genvar p = 0; p < RD_PORTS; p++) begin : g_rd
    always_ff @(posedge clk_i) begin
      if (re_i) begin
        rdata_o[p] <= mem_q[raddr_i[p]];
      end
    end
  end

endmodule

// File: hw/rtl/c8alu_alu.sv
// Instruction ALU: next PC, I, delay, VF and Vx from resolved operands.
// Depends on c8alu_pkg.
module c8alu_alu #(
  parameter int unsigned PROGRAM_BASE = c8alu_pkg::PROGRAM_BASE_DEF
) (
  input  c8alu_pkg::alu_req_t req_i,
  output c8alu_pkg::alu_rsp_t rsp_o
);

  localparam logic [15:0] BASE = 16'(PROGRAM_BASE);

  logic [7:0]  a, b, a2, b2, res, flag;
  logic [8:0]  sum;
  logic [15:0] addr16, target, skip_pc;
  logic        wr, flag_wr, x_is_f, y_is_f;

  always_comb begin
    a       = req_i.vx;
    b       = req_i.vy;
    x_is_f  = (req_i.item.reg_x == c8alu_pkg::VREG_FLAG);
    y_is_f  = (req_i.item.reg_y == c8alu_pkg::VREG_FLAG);
    addr16  = {4'b0, req_i.item.target_addr};
    target  = BASE + addr16 - c8alu_pkg::PC_STEP;
    skip_pc = req_i.pc + c8alu_pkg::PC_STEP;
    sum     = {1'b0, a} + {1'b0, b};
    flag    = 8'd0;
    wr      = 1'b0;
    flag_wr = 1'b0;

    unique case (req_i.item.func)
      c8alu_pkg::FUNC_SUB, c8alu_pkg::FUNC_SUBN: flag = {7'b0, 1'b0};
      default: flag = 8'd0;
    endcase

    // Flag-then-result ops see the flag already in VF.
    unique case (req_i.item.func)
      c8alu_pkg::FUNC_ADD:  flag = {7'b0, sum[8]};
      c8alu_pkg::FUNC_SUB:  flag = {7'b0, (a > b)};
      c8alu_pkg::FUNC_SHR:  flag = {7'b0, b[0]};
      c8alu_pkg::FUNC_SUBN: flag = {7'b0, (b > a)};
      c8alu_pkg::FUNC_SHL:  flag = {7'b0, b[7]};
      default:              flag = 8'd0;
    endcase
    a2  = x_is_f ? flag : a;
    b2  = y_is_f ? flag : b;
    res = a;

    rsp_o       = '0;
    rsp_o.pc    = req_i.pc;
    rsp_o.index = req_i.index;
    rsp_o.delay = req_i.delay;
    rsp_o.vf    = req_i.vf;

    unique case (req_i.item.func)
      c8alu_pkg::FUNC_RET: begin
        rsp_o.pc  = req_i.stack_top;
        rsp_o.pop = 1'b1;
      end
      c8alu_pkg::FUNC_JMP: rsp_o.pc = target;
      c8alu_pkg::FUNC_CALL: begin
        rsp_o.pc   = target;
        rsp_o.push = 1'b1;
      end
      c8alu_pkg::FUNC_SEQ_IMM: if (a == req_i.item.imm_byte) rsp_o.pc = skip_pc;
      c8alu_pkg::FUNC_SNE_IMM: if (a != req_i.item.imm_byte) rsp_o.pc = skip_pc;
      c8alu_pkg::FUNC_SEQ_REG: if (a == b) rsp_o.pc = skip_pc;
      c8alu_pkg::FUNC_SNE_REG: if (a != b) rsp_o.pc = skip_pc;
      c8alu_pkg::FUNC_LD_IMM: begin
        res = req_i.item.imm_byte;
        wr  = 1'b1;
      end
      c8alu_pkg::FUNC_ADD_IMM: begin
        res = a + req_i.item.imm_byte;
        wr  = 1'b1;
      end
      c8alu_pkg::FUNC_MOV: begin
        res = b;
        wr  = 1'b1;
      end
      c8alu_pkg::FUNC_OR: begin
        res = a | b;
        wr  = 1'b1;
      end
      c8alu_pkg::FUNC_AND: begin
        res = a & b;
        wr  = 1'b1;
      end
      c8alu_pkg::FUNC_XOR: begin
        res = a ^ b;
        wr  = 1'b1;
      end
      c8alu_pkg::FUNC_ADD: begin
        res     = sum[7:0];
        wr      = 1'b1;
        flag_wr = 1'b1;
      end
      c8alu_pkg::FUNC_SUB: begin
        res     = a2 - b2;
        wr      = 1'b1;
        flag_wr = 1'b1;
      end
      c8alu_pkg::FUNC_SHR: begin
        res     = {1'b0, b2[7:1]};
        wr      = 1'b1;
        flag_wr = 1'b1;
      end
      c8alu_pkg::FUNC_SUBN: begin
        res     = b2 - a2;
        wr      = 1'b1;
        flag_wr = 1'b1;
      end
      c8alu_pkg::FUNC_SHL: begin
        res     = {b2[6:0], 1'b0};
        wr      = 1'b1;
        flag_wr = 1'b1;
      end
      c8alu_pkg::FUNC_LD_I:   rsp_o.index = BASE + addr16;
      c8alu_pkg::FUNC_JMP_V0: rsp_o.pc = target + {8'b0, b};
      c8alu_pkg::FUNC_RND: begin
        res = req_i.item.random_byte & req_i.item.imm_byte;
        wr  = 1'b1;
      end
      c8alu_pkg::FUNC_RD_DT: begin
        res = req_i.delay;
        wr  = 1'b1;
      end
      c8alu_pkg::FUNC_LD_DT:  rsp_o.delay = a;
      c8alu_pkg::FUNC_ADD_I:  rsp_o.index = req_i.index + {8'b0, a};
      c8alu_pkg::FUNC_FONT:   rsp_o.index = {8'b0, a} * c8alu_pkg::FONT_STRIDE;
      default: ;
    endcase

    // Flag goes in first, then the result, which wins for a VF destination.
    if (flag_wr) rsp_o.vf = flag;
    if (wr && x_is_f) rsp_o.vf = res;
    rsp_o.vx      = wr ? res : a;
    rsp_o.vreg_we = wr && !x_is_f;
  end

endmodule

// File: hw/rtl/c8alu_checker.sv
// Port-level checker of the execute core, bound to the top level.
// Depends on c8alu_pkg and chip8_register_alu_execute_core_defines.svh.
`include "chip8_register_alu_execute_core_defines.svh"

module c8alu_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input c8alu_pkg::out_item_t out_data_o
);

  logic in_xfer, out_held;
  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_held = out_valid_o && out_stall_i;

  // A stalled result stays offered and unchanged.
  `C8ALU_ASSERT_NXT(a_out_valid_hold, out_held, out_valid_o, "result dropped while stalled")
  `C8ALU_ASSERT_NXT(a_out_data_hold, out_held, $stable(out_data_o), "stalled result changed")

  // The input stalls only behind a stalled, waiting result.
  `C8ALU_ASSERT_IMP(a_stall_cause, in_stall_o, out_held, "input stalled without back-pressure")

  // A result appearing on an empty output comes from a transfer that went through the execute stage.
  `C8ALU_ASSERT_IMP(a_rise_lat, $rose(out_valid_o), $past(in_xfer, 2), "result without a transfer")

endmodule

bind chip8_register_alu_execute_core c8alu_checker u_c8alu_checker (.*);

// File: tb/tb_chip8_register_alu_execute_core.sv
`timescale 1ns / 1ps
// Self-checking bench of the CHIP-8 style execute core: a directed table, then random
// instructions, each result compared with an in-bench model of the machine state.
// Depends on c8alu_pkg and chip8_register_alu_execute_core.
module tb_chip8_register_alu_execute_core;
  import c8alu_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 1640;
  localparam int unsigned IDLE_LIMIT    = 2000;  // cycles without any transfer
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned MAX_REPORTS   = 200;
  localparam int unsigned RESET_CYCLES  = 12;
  localparam logic [4:0]  FUNC_SPARE_LO = 5'd25;
  localparam logic [4:0]  FUNC_SPARE_HI = 5'd31;
  localparam logic [15:0] BASE16        = 16'(PROGRAM_BASE_DEF);
  localparam out_item_t   NO_GOLDEN     = '0;

  // One row of the directed table; golden_en marks a hand-typed result.
  typedef struct packed {
    in_item_t  instr;
    logic      golden_en;
    out_item_t golden;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  // Model of the architectural state
  logic [7:0]  vreg_m  [VREG_COUNT];
  logic [15:0] stack_m [STACK_DEPTH_DEF];
  logic [15:0] pc_m;
  logic [15:0] index_m;
  logic [7:0]  delay_m;
  int unsigned sp_m;

  out_item_t   arch_state_q [$];  // machine state expected after each accepted instruction
  int unsigned mismatches  = 0;
  int unsigned idle_cycles = 0;
  bit          calm_phase  = 1'b0;  // suppress all idling on both sides

  chip8_register_alu_execute_core #(
    .PROGRAM_BASE (PROGRAM_BASE_DEF),
    .STACK_DEPTH  (STACK_DEPTH_DEF)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // 2 ns period: high and low phase of 1 ns each.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Jump and call destinations sit 2 below the target, since fetch adds 2 afterwards.
  function automatic logic [15:0] jump_dest(input logic [15:0] offs);
    return BASE16 + offs - PC_STEP;
  endfunction

  // Retire one instruction on the model and return the state it leaves behind.
  function automatic out_item_t retire_instr(input in_item_t instr);
    logic [3:0] x;
    logic [3:0] y;
    logic [8:0] sum;
    x = instr.reg_x;
    y = instr.reg_y;
    case (instr.func)
      FUNC_RET: begin
        // load from the current slot, clear it, then step back (wrapping below zero)
        pc_m          = stack_m[sp_m];
        stack_m[sp_m] = '0;
        sp_m          = (sp_m == 0) ? STACK_DEPTH_DEF - 1 : sp_m - 1;
      end
      FUNC_JMP: pc_m = jump_dest({4'h0, instr.target_addr});
      FUNC_CALL: begin
        // advance first (wrapping past the top), then save the current PC
        sp_m          = (sp_m + 1 >= STACK_DEPTH_DEF) ? 0 : sp_m + 1;
        stack_m[sp_m] = pc_m;
        pc_m          = jump_dest({4'h0, instr.target_addr});
      end
      FUNC_SEQ_IMM: if (vreg_m[x] == instr.imm_byte) pc_m = pc_m + PC_STEP;
      FUNC_SNE_IMM: if (vreg_m[x] != instr.imm_byte) pc_m = pc_m + PC_STEP;
      FUNC_SEQ_REG: if (vreg_m[x] == vreg_m[y]) pc_m = pc_m + PC_STEP;
      FUNC_SNE_REG: if (vreg_m[x] != vreg_m[y]) pc_m = pc_m + PC_STEP;
      FUNC_LD_IMM:  vreg_m[x] = instr.imm_byte;
      FUNC_ADD_IMM: vreg_m[x] = vreg_m[x] + instr.imm_byte;
      FUNC_MOV:     vreg_m[x] = vreg_m[y];
      FUNC_OR:      vreg_m[x] = vreg_m[x] | vreg_m[y];
      FUNC_AND:     vreg_m[x] = vreg_m[x] & vreg_m[y];
      FUNC_XOR:     vreg_m[x] = vreg_m[x] ^ vreg_m[y];
      FUNC_ADD: begin
        // the sum is formed from the old operands, before VF is touched
        sum               = {1'b0, vreg_m[x]} + {1'b0, vreg_m[y]};
        vreg_m[VREG_FLAG] = {7'd0, sum[8]};
        vreg_m[x]         = sum[7:0];
      end
      // From here on VF is written first and the result reads the updated file,
      // so a VF operand or destination sees the new flag.
      FUNC_SUB: begin
        vreg_m[VREG_FLAG] = {7'd0, vreg_m[x] > vreg_m[y]};
        vreg_m[x]         = vreg_m[x] - vreg_m[y];
      end
      FUNC_SUBN: begin
        vreg_m[VREG_FLAG] = {7'd0, vreg_m[y] > vreg_m[x]};
        vreg_m[x]         = vreg_m[y] - vreg_m[x];
      end
      FUNC_SHR: begin
        vreg_m[VREG_FLAG] = {7'd0, vreg_m[y][0]};
        vreg_m[x]         = vreg_m[y] >> 1;
      end
      FUNC_SHL: begin
        vreg_m[VREG_FLAG] = {7'd0, vreg_m[y][7]};
        vreg_m[x]         = vreg_m[y] << 1;
      end
      FUNC_LD_I:   index_m = BASE16 + {4'h0, instr.target_addr};
      FUNC_JMP_V0: pc_m = jump_dest({4'h0, instr.target_addr} + {8'h00, vreg_m[VREG_ZERO]});
      FUNC_RND:    vreg_m[x] = instr.random_byte & instr.imm_byte;
      FUNC_RD_DT:  vreg_m[x] = delay_m;
      FUNC_LD_DT:  delay_m = vreg_m[x];
      FUNC_ADD_I:  index_m = index_m + {8'h00, vreg_m[x]};
      FUNC_FONT:   index_m = {8'h00, vreg_m[x]} * FONT_STRIDE;
      default: ;  // spare codes leave everything as it is
    endcase
    return '{new_pc: pc_m, new_index: index_m, vx_value: vreg_m[x],
             flag_value: vreg_m[VREG_FLAG], delay_value: delay_m};
  endfunction

  // Idle length: mostly none, often short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (calm_phase || pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic stim_row_t op(input logic [4:0] f, input logic [3:0] x,
                                   input logic [3:0] y, input logic [7:0] imm,
                                   input logic [11:0] addr, input logic [7:0] rnd,
                                   input logic gold_en, input out_item_t gold);
    return '{instr: '{f, x, y, imm, addr, rnd}, golden_en: gold_en, golden: gold};
  endfunction

  function automatic in_item_t random_instr();
    in_item_t    instr;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) instr.func = 5'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
    else          instr.func = 5'($urandom_range(FUNC_RET, FUNC_FONT));
    instr.reg_x       = 4'($urandom);
    instr.reg_y       = 4'($urandom);
    instr.target_addr = 12'($urandom);
    instr.random_byte = 8'($urandom);
    // lean on the byte extremes now and then to hit carries and borrows
    case ($urandom_range(0, 9))
      0:       instr.imm_byte = 8'h00;
      1:       instr.imm_byte = 8'hFF;
      2:       instr.imm_byte = 8'h80;
      default: instr.imm_byte = 8'($urandom);
    endcase
    return instr;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%04h want 0x%04h", name, got, want));
  endtask

  // Offer one instruction and hold it until the transfer happens. Called and
  // left at a falling edge; valid stays high into the next call when no gap follows.
  task automatic send_instr(input stim_row_t row);
    int unsigned gap;
    out_item_t   predicted;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= row.instr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // the model advances on every row; a typed-in result replaces its prediction
    predicted = retire_instr(row.instr);
    arch_state_q.push_back(row.golden_en ? row.golden : predicted);
    @(negedge clk);
  endtask

  // Result side: compare every transfer with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (arch_state_q.size() == 0) begin
        report_mismatch("result with no instruction outstanding");
      end else begin
        want = arch_state_q.pop_front();
        check_field("new_pc",      out_data.new_pc,             want.new_pc);
        check_field("new_index",   out_data.new_index,          want.new_index);
        check_field("vx_value",    {8'h00, out_data.vx_value},    {8'h00, want.vx_value});
        check_field("flag_value",  {8'h00, out_data.flag_value},  {8'h00, want.flag_value});
        check_field("delay_value", {8'h00, out_data.delay_value}, {8'h00, want.delay_value});
      end
    end
  end

  // Watchdog: end the run if neither channel has moved for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver back-pressure: stall bursts of random length between free runs.
  initial begin
    int unsigned hold;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      hold = pick_gap();
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  initial begin
    stim_row_t directed_q [$];
    stim_row_t row;

    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;

    // initialise the model to the reset state
    foreach (vreg_m[i])  vreg_m[i]  = '0;
    foreach (stack_m[i]) stack_m[i] = '0;
    pc_m    = BASE16;
    index_m = '0;
    delay_m = '0;
    sp_m    = 0;

    // Directed table: field extremes, every operation, stack wrap, VF as destination.
    directed_q.push_back(op(FUNC_LD_IMM, 4'h0, 4'h0, 8'hFF, 12'h000, 8'h00,
                            1'b1, '{16'h0200, 16'h0000, 8'hFF, 8'h00, 8'h00}));
    directed_q.push_back(op(FUNC_LD_IMM, 4'h1, 4'h0, 8'h01, 12'h000, 8'h00,
                            1'b1, '{16'h0200, 16'h0000, 8'h01, 8'h00, 8'h00}));
    // 0xFF + 0x01 carries out: VF set, V0 wraps to zero
    directed_q.push_back(op(FUNC_ADD, 4'h0, 4'h1, 8'h00, 12'h000, 8'h00,
                            1'b1, '{16'h0200, 16'h0000, 8'h00, 8'h01, 8'h00}));
    // jump to the top address: base + 0xFFF - 2
    directed_q.push_back(op(FUNC_JMP, 4'h0, 4'h0, 8'h00, 12'hFFF, 8'h00,
                            1'b1, '{16'h11FD, 16'h0000, 8'h00, 8'h01, 8'h00}));
    directed_q.push_back(op(FUNC_CALL, 4'h0, 4'h0, 8'h00, 12'h000, 8'h00, 1'b0, NO_GOLDEN));
    directed_q.push_back(op(FUNC_RET, 4'h0, 4'h0, 8'h00, 12'h000, 8'h00, 1'b0, NO_GOLDEN));
    // return on an empty stack: slot zero is clear, pointer wraps to the top
    directed_q.push_back(op(FUNC_RET, 4'h0, 4'h0, 8'h00, 12'h000, 8'h00,
                            1'b1, '{16'h0000, 16'h0000, 8'h00, 8'h01, 8'h00}));
    directed_q.push_back(op(FUNC_LD_IMM,  4'h2, 4'h0, 8'h80, 12'h000, 8'h00, 1'b0, NO_GOLDEN));
    directed_q.push_back(op(FUNC_SEQ_IMM, 4'h2, 4'h0, 8'h80, 12'h000, 8'h00, 1'b0, NO_GOLDEN));
    directed_q.push_back(op(FUNC_SNE_IMM, 4'h2, 4'h0, 8'h80, 12'h000, 8'h00, 1'b0, NO_GOLDEN));
    directed_q.push_back(op(FUNC_SEQ_REG, 4'h0, 4'h3, 8'h00, 12'h000, 8'h00, 1'b0, NO_GOLDEN));
    directed_q.push_back(op(FUNC_SNE_REG, 4'h1, 4'h2, 8'h00, 12'h000, 8'h00, 1'b0, NO_GOLDEN));
    directed_q.push_back(op(FUNC_ADD_IMM, 4'h2, 4'h0, 8'hFF, 12'h000, 8'h00, 1'b0, NO_GOLDEN));
    directed_q.push_back(op(FUNC_MOV,     4'h3, 4'h2, 8'h00, 12'h000, 8'h00, 1'b0, NO_GOLDEN));
    directed_q.push_back(op(FUNC_OR,      4'h3, 4'h1, 8'h00, 12'h000, 8'h00, 1'b0, NO_GOLDEN));
    directed_q.push_back(op(FUNC_AND,     4'h3, 4'h2, 8'h00, 12'h000, 8'h00, 1'b0, NO_GOLDEN));
    directed_q.push_back(op(FUNC_XOR,     4'h3, 4'h0, 8'h00, 12'h000, 8'h00, 1'b0, NO_GOLDEN));
    // borrow, then equal operands: the strict compare leaves VF clear
    directed_q.push_back(op(FUNC_SUB,     4'h1, 4'h2, 8'h00, 12'h000, 8'h00, 1'b0, NO_GOLDEN));
    directed_q.push_back(op(FUNC_SUB,     4'h4, 4'h4, 8'h00, 12'h000, 8'h00, 1'b0, NO_GOLDEN));
    // VF as destination: the result overwrites the flag
    directed_q.push_back(op(FUNC_SHR,     4'hF, 4'h2, 8'h00, 12'h000, 8'h00, 1'b0, NO_GOLDEN));
    directed_q.push_back(op(FUNC_SUBN,    4'hF, 4'h3, 8'h00, 12'h000, 8'h00, 1'b0, NO_GOLDEN));
    directed_q.push_back(op(FUNC_LD_I,    4'h0, 4'h0, 8'h00, 12'hFFF, 8'h00, 1'b0, NO_GOLDEN));
    directed_q.push_back(op(FUNC_LD_IMM,  4'h0, 4'h0, 8'hFF, 12'h000, 8'h00, 1'b0, NO_GOLDEN));
    // shift left of 0xFF: VF takes bit 7
    directed_q.push_back(op(FUNC_SHL,     4'h5, 4'h0, 8'h00, 12'h000, 8'h00, 1'b0, NO_GOLDEN));
    directed_q.push_back(op(FUNC_JMP_V0,  4'h0, 4'h0, 8'h00, 12'hFFF, 8'h00, 1'b0, NO_GOLDEN));
    directed_q.push_back(op(FUNC_RND,     4'h6, 4'h0, 8'hFF, 12'h000, 8'hA5, 1'b0, NO_GOLDEN));
    directed_q.push_back(op(FUNC_LD_DT,   4'h6, 4'h0, 8'h00, 12'h000, 8'h00, 1'b0, NO_GOLDEN));
    directed_q.push_back(op(FUNC_RD_DT,   4'h7, 4'h0, 8'h00, 12'h000, 8'h00, 1'b0, NO_GOLDEN));
    directed_q.push_back(op(FUNC_ADD_I,   4'h0, 4'h0, 8'h00, 12'h000, 8'h00, 1'b0, NO_GOLDEN));
    directed_q.push_back(op(FUNC_FONT,    4'h0, 4'h0, 8'h00, 12'h000, 8'h00, 1'b0, NO_GOLDEN));
    directed_q.push_back(op(FUNC_SPARE_HI, 4'h8, 4'hF, 8'hFF, 12'hFFF, 8'hFF, 1'b0, NO_GOLDEN));

    // hold reset first, then release it at a falling edge
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_q[i]) send_instr(directed_q[i]);

    // Random part, with a calm stretch in the middle and periodic stack sweeps.
    row.golden_en = 1'b0;
    row.golden    = NO_GOLDEN;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm_phase = (n >= 900 && n < 1100);
      if (n % 300 == 150) begin
        // drive the pointer past the top and back below zero
        for (int k = 0; k < STACK_DEPTH_DEF + 3; k++) begin
          row.instr      = random_instr();
          row.instr.func = FUNC_CALL;
          send_instr(row);
        end
        for (int k = 0; k < STACK_DEPTH_DEF + 3; k++) begin
          row.instr      = random_instr();
          row.instr.func = FUNC_RET;
          send_instr(row);
        end
      end
      row.instr = random_instr();
      send_instr(row);
    end
    calm_phase = 1'b0;
    in_valid <= 1'b0;

    // drain: wait for every outstanding result, then wait on for strays
    while (arch_state_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
